/* rtl/escaped_frame_receiver_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame receiver.
// Each macro checks a property on the rising edge of aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH

// Property that must hold at every active clock edge.
`define EFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define EFR_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/efr_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared constants: control bytes, result kinds and payload widths.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned ADDR_W   = 3;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [BYTE_W-1:0] ESCAPE_XOR  = 8'h20;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd900;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_BYTE    = 2'd0;
    localparam kind_t KIND_GOOD    = 2'd1;
    localparam kind_t KIND_BAD_SUM = 2'd2;
    localparam kind_t KIND_REJECT  = 2'd3;

endpackage

/* rtl/escaped_frame_receiver_top.sv */
// A result is registered in the output register, or in the skid stage while m_* is held.
// Throughput: one byte per cycle unless the skid is full; the per-byte update is registered.
// The output register and a one-entry skid stage let s_tready stay high while one result waits.
// Reset: aresetn is synchronous and active low; it clears the parser and both output stages.
// After reset the parser expects a length high byte, and max_frame_length reads 900.
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Unescapes a received byte stream, parses length-prefixed frames, passes
// frame bytes on as they arrive and reports a good, bad or rejected end.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_top_macros.svh"

module escaped_frame_receiver_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream: s_tdata[7:0] = raw_byte
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [efr_pkg::S_DATA_W-1:0] s_tdata,
    // Result stream: m_tdata[7:0] = value, m_tdata[23:8] = frame_length
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [efr_pkg::M_DATA_W-1:0] m_tdata,
    // m_tuser[1:0] = kind
    output logic [efr_pkg::KIND_W-1:0]   m_tuser,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efr_pkg::ADDR_W-1:0]   paddr,
    input  logic [efr_pkg::CFG_W-1:0]    pwdata,
    output logic [efr_pkg::CFG_W-1:0]    prdata,
    output logic                         pready
);

    import efr_pkg::*;

    // Parser phases.
    localparam logic [2:0] PH_LEN_HI = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CHECK  = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    // Configuration register.
    logic [LEN_W-1:0]  max_len_reg;
    logic              cfg_write;
    logic              cfg_hit;

    // Parser state.
    logic [2:0]        phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  count_reg, count_next;

    // Output register and skid stage.
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    kind_t               skid_kind_reg, skid_kind_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;

    // Per-request decode.
    logic              s_accept;
    logic [BYTE_W-1:0] raw_byte;
    logic [BYTE_W-1:0] rx_byte;
    logic              is_start;
    logic              is_escape;
    logic [LEN_W-1:0]  len_cat;
    logic [LEN_W:0]    count_inc;
    logic [BYTE_W-1:0] check_total;

    logic              res_valid;
    kind_t             res_kind;
    logic [BYTE_W-1:0] res_value;
    logic [LEN_W-1:0]  res_len;
    logic              out_free;

    // ------------------------------------------------------------------
    // Configuration port. The register answers at every address with paddr[2]
    // low (0 to 3); addresses 4 to 7 are ignored on write and read as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[ADDR_W-1] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {{(CFG_W-LEN_W){1'b0}}, max_len_reg} : '0;

    // ------------------------------------------------------------------
    // Input side. A request is taken whenever the skid stage is empty, so
    // a single result may wait on the output while the next byte comes in.
    // ------------------------------------------------------------------
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign raw_byte  = s_tdata[BYTE_W-1:0];

    // A byte that follows an escape is never a start or an escape itself.
    assign is_start  = !esc_reg && (raw_byte == START_BYTE);
    assign is_escape = !esc_reg && (raw_byte == ESCAPE_BYTE);
    assign rx_byte   = esc_reg ? (raw_byte ^ ESCAPE_XOR) : raw_byte;

    assign len_cat     = {len_reg[LEN_W-1:BYTE_W], rx_byte};
    assign count_inc   = {1'b0, count_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign check_total = sum_reg + rx_byte + 8'd1;

    // ------------------------------------------------------------------
    // Frame parser: the whole update for one byte happens in this pass.
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_BYTE;
        res_value  = '0;
        res_len    = '0;

        if (s_accept) begin
            if (is_start) begin
                // A start byte restarts the frame from any phase and is
                // passed on as a frame byte.
                phase_next = PH_LEN_HI;
                sum_next   = '0;
                count_next = '0;
                len_next   = '0;
                res_valid  = 1'b1;
                res_value  = raw_byte;
            end else if (is_escape) begin
                // The escape byte itself gives no result, even when idle.
                esc_next = 1'b1;
            end else begin
                esc_next = 1'b0;
                case (phase_reg)
                    PH_LEN_HI: begin
                        len_next   = {rx_byte, {BYTE_W{1'b0}}};
                        phase_next = PH_LEN_LO;
                        res_valid  = 1'b1;
                        res_value  = rx_byte;
                    end
                    PH_LEN_LO: begin
                        len_next  = len_cat;
                        res_valid = 1'b1;
                        if (len_cat > max_len_reg) begin
                            // Over-limit length: reject and wait for a start.
                            phase_next = PH_IDLE;
                            res_kind   = KIND_REJECT;
                            res_len    = len_cat;
                        end else begin
                            count_next = '0;
                            phase_next = (len_cat == '0) ? PH_CHECK : PH_DATA;
                            res_value  = rx_byte;
                        end
                    end
                    PH_DATA: begin
                        sum_next   = sum_reg + rx_byte;
                        count_next = count_inc[LEN_W-1:0];
                        if (count_inc >= {1'b0, len_reg}) begin
                            phase_next = PH_CHECK;
                        end
                        res_valid = 1'b1;
                        res_value = rx_byte;
                    end
                    PH_CHECK: begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_kind   = (check_total == '0) ? KIND_GOOD : KIND_BAD_SUM;
                        res_len    = len_reg;
                    end
                    default: begin
                        // Idle: ordinary bytes are dropped.
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage. The skid only fills when the
    // output holds a result that is not taken in the same cycle.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_kind_next  = skid_kind_reg;
        skid_data_next  = skid_data_reg;

        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_kind_next   = skid_kind_reg;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (res_valid) begin
                out_valid_next = 1'b1;
                out_kind_next  = res_kind;
                out_data_next  = {res_len, res_value};
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_kind_next  = res_kind;
            skid_data_next  = {res_len, res_value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RESET;
            phase_reg      <= PH_LEN_HI;
            esc_reg        <= 1'b0;
            len_reg        <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_write && cfg_hit) begin
                max_len_reg <= pwdata[LEN_W-1:0];
            end
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            len_reg        <= len_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        skid_kind_reg <= skid_kind_next;
        skid_data_reg <= skid_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `EFR_ASSERT(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid full with output empty")

    `EFR_ASSERT(a_data_count, (phase_reg != PH_DATA) || (count_reg < len_reg), "data count overran length")

    `EFR_ASSERT_NEXT(a_escape_sets_pending, s_accept && is_escape, esc_reg && !$past(res_valid), "escape not recorded")

    `EFR_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg && $stable(skid_data_reg), "skid entry lost")

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Drives raw serial bytes into the receiver and keeps a cycle-free model of
// the unescaping and frame parser. Every result request is compared, field
// by field, with the oldest predicted result. The run covers the control
// bytes, length limits, broken frames and heavy back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;
    import efr_pkg::*;

    // Clock period is 8 ns; the watchdog allows for the long receiver
    // hold-off several times over.
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned HOLD_OFF_LEN   = 300;
    localparam int unsigned RANDOM_PHASE   = 250;

    // Register addresses: max_frame_length is register 0, address 4
    // holds no register at all.
    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_NO_REG  = 3'd4;

    // Parser phases of the frame decoder.
    typedef enum logic [2:0] {
        ST_LEN_HI,
        ST_LEN_LO,
        ST_DATA,
        ST_CHECK,
        ST_IDLE
    } parse_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  frame_len;
    } rx_result_t;

    // ------------------------------------------------------------------
    // Ports of the block. All inputs hold a known value from time zero.
    // ------------------------------------------------------------------
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [CFG_W-1:0]    pwdata   = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    escaped_frame_receiver_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder model: its own copy of the parser state and of the limit.
    // ------------------------------------------------------------------
    parse_state_t      dec_state   = ST_LEN_HI;
    logic              dec_escaped = 1'b0;
    logic [LEN_W-1:0]  dec_len     = '0;
    logic [BYTE_W-1:0] dec_sum     = '0;
    logic [16:0]       dec_taken   = '0;
    logic [LEN_W-1:0]  max_len_cfg = MAX_LEN_RESET;

    rx_result_t        pending_results[$];
    rx_result_t        oldest;

    int unsigned       mismatches  = 0;
    int unsigned       bytes_sent  = 0;
    int unsigned       idle_cycles = 0;

    // Knobs shared by the test tasks and the two stream processes.
    bit                tx_gaps_on  = 1'b1;
    bit                rx_gaps_on  = 1'b1;
    int unsigned       rx_hold_req = 0;
    int unsigned       rx_stall_left = 0;

    task automatic queue_result(input kind_t kind, input logic [BYTE_W-1:0] value,
                                input logic [LEN_W-1:0] frame_len);
        rx_result_t r;
        r.kind      = kind;
        r.value     = value;
        r.frame_len = frame_len;
        pending_results.insert(pending_results.size(), r);
    endtask

    // Advances the decoder model by one accepted raw byte and queues the
    // result it causes, if any.
    task automatic decode_rx_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] total;
        b = raw;
        if (!dec_escaped && raw == START_BYTE) begin
            // A start byte restarts the frame from any phase; a half-seen
            // frame is dropped without a status.
            dec_state = ST_LEN_HI;
            dec_sum   = '0;
            dec_taken = '0;
            dec_len   = '0;
            queue_result(KIND_BYTE, raw, '0);
            return;
        end
        if (!dec_escaped && raw == ESCAPE_BYTE) begin
            dec_escaped = 1'b1;
            return;
        end
        if (dec_escaped) begin
            b = raw ^ ESCAPE_XOR;
            dec_escaped = 1'b0;
        end
        case (dec_state)
            ST_LEN_HI: begin
                dec_len   = {b, 8'h00};
                dec_state = ST_LEN_LO;
                queue_result(KIND_BYTE, b, '0);
            end
            ST_LEN_LO: begin
                dec_len[7:0] = b;
                if (dec_len > max_len_cfg) begin
                    dec_state = ST_IDLE;
                    queue_result(KIND_REJECT, '0, dec_len);
                end else begin
                    dec_taken = '0;
                    dec_state = (dec_len == '0) ? ST_CHECK : ST_DATA;
                    queue_result(KIND_BYTE, b, '0);
                end
            end
            ST_DATA: begin
                dec_sum   = dec_sum + b;
                dec_taken = dec_taken + 17'd1;
                if (dec_taken >= {1'b0, dec_len}) dec_state = ST_CHECK;
                queue_result(KIND_BYTE, b, '0);
            end
            ST_CHECK: begin
                total     = dec_sum + b + 8'd1;
                dec_state = ST_IDLE;
                queue_result((total == 8'd0) ? KIND_GOOD : KIND_BAD_SUM, '0, dec_len);
            end
            default: begin
                dec_state = ST_IDLE;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result checker. Outputs are sampled at the rising edge, before the
    // block's own updates of that edge land.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result (kind in got)", 32'(m_tuser), 32'hFFFF_FFFF);
            end else begin
                oldest = pending_results.pop_front();
                if (m_tuser != oldest.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(oldest.kind));
                if (m_tdata[7:0] != oldest.value)
                    report_mismatch("value", 32'(m_tdata[7:0]), 32'(oldest.value));
                if (m_tdata[23:8] != oldest.frame_len)
                    report_mismatch("frame_length", 32'(m_tdata[23:8]), 32'(oldest.frame_len));
            end
        end
    end

    // Watchdog: any request on either stream or on the register port counts
    // as progress. A run that stops moving ends here as a failure.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly short gaps, with the odd long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side. A hold-off request from a test keeps m_tready low for
    // a counted stretch; otherwise it stalls at random when allowed to.
    always @(negedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_stall_left = rx_hold_req;
            rx_hold_req   = 0;
        end
        if (rx_stall_left != 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            rx_stall_left = pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Entered just after a falling edge; returns after the next
    // falling edge once the byte's request has completed. s_tvalid stays
    // high between back-to-back bytes.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] raw);
        int unsigned gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 25) gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        decode_rx_byte(raw);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Sends a frame byte, escaping it when it is a control byte and now and
    // then when it is not.
    task automatic send_escaped(input logic [BYTE_W-1:0] b);
        if (b == START_BYTE || b == ESCAPE_BYTE || $urandom_range(0, 15) == 0) begin
            send_byte(ESCAPE_BYTE);
            send_byte(b ^ ESCAPE_XOR);
        end else begin
            send_byte(b);
        end
    endtask

    // Data bytes lean towards the control bytes and their escaped forms.
    function automatic logic [BYTE_W-1:0] pick_data();
        case ($urandom_range(0, 15))
            0:       return START_BYTE;
            1:       return ESCAPE_BYTE;
            2:       return START_BYTE ^ ESCAPE_XOR;
            3:       return ESCAPE_BYTE ^ ESCAPE_XOR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // A frame with the given length field and ndata data bytes. The checksum
    // follows only when all data bytes were sent; a short frame is left for
    // the next start byte to cut off.
    task automatic send_frame(input logic [LEN_W-1:0] flen, input int unsigned ndata,
                              input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] d;
        sum = '0;
        send_byte(START_BYTE);
        send_escaped(flen[15:8]);
        send_escaped(flen[7:0]);
        repeat (ndata) begin
            d = pick_data();
            sum = sum + d;
            send_escaped(d);
        end
        if (ndata == flen) begin
            if (bad_sum) send_escaped(~sum ^ 8'($urandom_range(1, 255)));
            else send_escaped(~sum);
        end
    endtask

    // One random stretch of traffic: mostly small well-formed frames with
    // random content, plus noise, over-limit lengths and cut-off frames.
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned top;
        int unsigned flen;
        int unsigned ndata;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 20 && max_len_cfg != 16'hFFFF) begin
            top  = 65534 - max_len_cfg;
            flen = max_len_cfg + 1;
            if ($urandom_range(0, 1) != 0) flen += $urandom_range(0, (top < 3) ? top : 3);
            else flen += $urandom_range(0, top);
            send_frame(16'(flen), $urandom_range(0, 2), 1'b0);
        end else if (pick < 23) begin
            // Any accepted length with at most 8 data bytes, cut short unless they cover it.
            flen  = $urandom_range(0, max_len_cfg);
            ndata = $urandom_range(0, (flen < 8) ? flen : 8);
            send_frame(16'(flen), ndata, 1'b0);
        end else begin
            top = (pick < 25) ? 60 : 12;
            if (top > max_len_cfg) top = max_len_cfg;
            flen  = $urandom_range(0, top);
            ndata = flen;
            if (flen != 0 && $urandom_range(0, 99) < 8) ndata = $urandom_range(0, flen - 1);
            send_frame(16'(flen), ndata, $urandom_range(0, 99) < 15);
        end
    endtask

    // Lowers s_tvalid, waits for every expected result and then for the
    // block's latency, since an escape or idle byte leaves no result behind.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Register port: setup cycle, then access cycle until pready.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        if (addr == ADDR_MAX_LEN) max_len_cfg = data[LEN_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
        logic [CFG_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        got = prdata;
        if (got != want) report_mismatch("register read", got, want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        apb_read_check(ADDR_MAX_LEN, {16'h0000, MAX_LEN_RESET});
    endtask

    // Without a start byte the parser takes the first byte as the length
    // high byte. Data byte 0xFF with checksum 0x00 closes a good frame.
    task automatic test_no_start_after_reset();
        send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF); send_byte(8'h00);
    endtask

    task automatic test_special_bytes();
        // Zero length: the byte after the length is the checksum, here bad.
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        // Escaped start, escaped escape, and a raw start after an escape,
        // which is data 0x5E rather than a new frame.
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h03);
        send_byte(ESCAPE_BYTE); send_byte(8'h5E);
        send_byte(ESCAPE_BYTE); send_byte(8'h5D);
        send_byte(ESCAPE_BYTE); send_byte(START_BYTE);
        send_byte(8'hA6);
        // Idle: escapes give nothing, and an escaped start is ignored too.
        send_byte(ESCAPE_BYTE); send_byte(8'h41);
        send_byte(ESCAPE_BYTE); send_byte(START_BYTE);
        // Length 0x0385 is one above the reset limit and is rejected.
        send_byte(START_BYTE); send_byte(8'h03); send_byte(8'h85);
        // A start inside a frame drops it; the new zero-length frame is good.
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h04); send_byte(8'h11);
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
    endtask

    task automatic test_register_writes();
        wait_results_drained();
        // A write to an unused address must leave the limit alone.
        apb_write(ADDR_NO_REG, $urandom());
        apb_read_check(ADDR_MAX_LEN, {16'h0000, max_len_cfg});
        // Upper write bits are random and must not reach the register.
        apb_write(ADDR_MAX_LEN, {16'($urandom_range(0, 65535)), 16'd12});
        apb_read_check(ADDR_MAX_LEN, 32'd12);
        send_frame(16'd12, 12, 1'b0);
        send_frame(16'd13, 0, 1'b0);
        send_frame(16'd12, 12, 1'b1);
        wait_results_drained();
    endtask

    // The receiver holds off for a long counted stretch while the sender
    // keeps offering bytes without gaps, so the block fills and stalls its
    // input. Then the sender pauses until every result has come.
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_hold_req = HOLD_OFF_LEN;
        send_frame(16'd10, 10, 1'b0);
        send_frame(16'd8, 8, 1'b1);
        send_frame(16'd6, 6, 1'b0);
        tx_gaps_on = 1'b1;
        wait_results_drained();
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back();
        int unsigned target;
        target = bytes_sent + 120;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        while (bytes_sent < target) send_random_frame();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        wait_results_drained();
    endtask

    // Random traffic under several limits, the extremes among them.
    task automatic test_random_traffic();
        logic [LEN_W-1:0] limits[5];
        int unsigned      target;
        limits[0] = 16'hFFFF;
        limits[1] = 16'h0000;
        limits[2] = 16'($urandom_range(1, 65534));
        limits[3] = 16'd40;
        limits[4] = MAX_LEN_RESET;
        foreach (limits[i]) begin
            apb_write(ADDR_MAX_LEN, {16'($urandom_range(0, 65535)), limits[i]});
            target = bytes_sent + RANDOM_PHASE;
            while (bytes_sent < target) send_random_frame();
            wait_results_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, run the tests in turn, then drain.
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_defaults();
        test_no_start_after_reset();
        test_special_bytes();
        test_register_writes();
        test_backpressure();
        test_back_to_back();
        test_random_traffic();

        wait_results_drained();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/efr_pkg.sv
rtl/escaped_frame_receiver_top.sv
test/tb.sv
